// ===== rtl/core/fded_pkg.sv =====
package fded_pkg;

	localparam int CHAN_W      = 8;
	localparam int MODE_W      = 2;
	localparam int THRESH_W    = 9;
	localparam int ROW_WIDTH_W = 12;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int GRAY_SUM_W  = 11;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 12'd2048;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd2;

	// operating modes
	localparam logic [MODE_W-1:0] MODE_EDGE_BLACK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FLAT_BLACK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COLOR_GRAD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_GRAY_GRAD  = 2'd3;

	// input commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic              command;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic              row_end;
	} out_item_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [THRESH_W-1:0] threshold;
	} kernel_cfg_t;

endpackage

// ===== rtl/core/fded_line_store.sv =====
module fded_line_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  fded_pkg::pixel_t    wdata,
	input  logic [AW-1:0]       raddr_a,
	input  logic [AW-1:0]       raddr_b,
	output fded_pkg::pixel_t    rdata_a,
	output fded_pkg::pixel_t    rdata_b
);
	import fded_pkg::*;

	pixel_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads, same-cycle write forwarded
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr_a)) begin
			rdata_a <= wdata;
		end else begin
			rdata_a <= mem_q[raddr_a];
		end
		if (we && (waddr == raddr_b)) begin
			rdata_b <= wdata;
		end else begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== rtl/core/fded_kernel.sv =====
module fded_kernel (
	input  fded_pkg::pixel_t      p,
	input  fded_pkg::pixel_t      e,
	input  fded_pkg::pixel_t      s,
	input  logic                  pass_thru,
	input  fded_pkg::kernel_cfg_t cfg,
	output fded_pkg::pixel_t      px
);
	import fded_pkg::*;

	logic [CHAN_W-1:0]     de_r, de_g, de_b;
	logic [CHAN_W-1:0]     ds_r, ds_g, ds_b;
	pixel_t                grad;
	pixel_t                gray_src;
	logic                  any_hi;
	logic [GRAY_SUM_W-1:0] gray_sum;
	logic [CHAN_W-1:0]     gray;
	logic [CHAN_W-1:0]     gray_out;

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic at_thresh(input logic [CHAN_W-1:0] d,
			input logic [THRESH_W-1:0] th);
		return {1'b0, d} >= th;
	endfunction

	assign de_r = absdiff(p.red, e.red);
	assign de_g = absdiff(p.green, e.green);
	assign de_b = absdiff(p.blue, e.blue);
	assign ds_r = absdiff(p.red, s.red);
	assign ds_g = absdiff(p.green, s.green);
	assign ds_b = absdiff(p.blue, s.blue);

	assign any_hi = at_thresh(de_r, cfg.threshold) || at_thresh(ds_r, cfg.threshold) ||
		at_thresh(de_g, cfg.threshold) || at_thresh(ds_g, cfg.threshold) ||
		at_thresh(de_b, cfg.threshold) || at_thresh(ds_b, cfg.threshold);

	assign grad.red   = (de_r > ds_r) ? de_r : ds_r;
	assign grad.green = (de_g > ds_g) ? de_g : ds_g;
	assign grad.blue  = (de_b > ds_b) ? de_b : ds_b;

	// gray = (r + 5g + b/2) / 8, at most 207
	assign gray_src = pass_thru ? p : grad;
	assign gray_sum = GRAY_SUM_W'(gray_src.red) + (GRAY_SUM_W'(gray_src.green) << 2)
		+ GRAY_SUM_W'(gray_src.green) + GRAY_SUM_W'(gray_src.blue >> 1);
	assign gray     = gray_sum[GRAY_SUM_W-1:3];
	assign gray_out = ({1'b0, gray} >= cfg.threshold) ? CHAN_MAX : gray;

	always_comb begin
		px = p;
		case (cfg.mode)
			MODE_EDGE_BLACK: begin
				if (!pass_thru && any_hi) px = '0;
			end
			MODE_FLAT_BLACK: begin
				if (!pass_thru && !any_hi) px = '0;
			end
			MODE_COLOR_GRAD: begin
				if (!pass_thru) px = grad;
			end
			MODE_GRAY_GRAD: begin
				px.red   = gray_out;
				px.green = gray_out;
				px.blue  = gray_out;
			end
			default: begin
				px = p;
			end
		endcase
	end

endmodule

// ===== rtl/core/forward_difference_edge_detector.sv =====
// channel  direction  handshake                  payload
// pix      in         pix_valid / pix_ready      command, red, green, blue
// res      out        res_valid / res_ready      out_red, out_green, out_blue, row_end
// cfg      in         cfg_we (no wait)           cfg_index, cfg_data
//
// one pixel transfer per cycle unless res stalls or a cfg write is pending; a result
// follows the pixel below it through the operand register, then the result register
// the line store is a single-write, two-read memory with registered read data,
// read ahead so the held pixel and its east neighbor are ready for the next transfer
// pix_ready drops for the cycle of a cfg write and the cycle after, while the
// read-ahead reloads under the new row width
// no clearing pass after reset: the first row of a frame only fills the store
// a stalled res side backs up through the two registers into pix_ready
module forward_difference_edge_detector #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_ready,
	input  fded_pkg::in_item_t                   pix,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output fded_pkg::out_item_t                  res,
	input  logic                                 cfg_we,
	input  logic [fded_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fded_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fded_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	// wide enough for both the row_width register and MAX_WIDTH itself
	localparam int LW = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) : ROW_WIDTH_W;

	// configuration registers
	logic [MODE_W-1:0]      mode_q;
	logic [THRESH_W-1:0]    threshold_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic                   cfg_busy_q;

	// row tracking
	logic [AW-1:0] column_q;
	logic          first_row_q;

	logic [LW-1:0] w_ext;
	logic [LW-1:0] w_eff;
	logic [AW-1:0] last_col;
	logic [AW-1:0] col_eff;
	logic [AW-1:0] col_next;
	logic          is_last;
	logic          flush;
	logic          pix_xfer;
	logic          step;
	logic          emit;

	// line store read-ahead data
	pixel_t cur_px;
	pixel_t rd_p;
	pixel_t rd_e;

	// operand stage
	logic   valid_s1;
	pixel_t p_s1;
	pixel_t e_s1;
	pixel_t s_s1;
	logic   pass_s1;
	logic   row_end_s1;

	// result stage
	logic        res_valid_q;
	out_item_t   res_q;
	logic        out_free;
	logic        s1_fire;
	pixel_t      kern_px;
	kernel_cfg_t kern_cfg;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_EDGE_BLACK;
			threshold_q <= '0;
			row_width_q <= ROW_WIDTH_RESET;
			cfg_busy_q  <= 1'b0;
		end else begin
			cfg_busy_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:      mode_q      <= cfg_data[MODE_W-1:0];
					CFG_THRESHOLD: threshold_q <= cfg_data[THRESH_W-1:0];
					CFG_ROW_WIDTH: row_width_q <= cfg_data[ROW_WIDTH_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// effective width, clamped to [2, MAX_WIDTH]
	assign w_ext = LW'(row_width_q);
	always_comb begin
		w_eff = w_ext;
		if (w_ext < LW'(2)) begin
			w_eff = LW'(2);
		end else if (w_ext > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end
	end
	assign last_col = AW'(w_eff - LW'(1));

	// a column at or past the last (width shrank mid-row) counts as the last
	assign is_last = column_q >= last_col;
	assign col_eff = is_last ? last_col : column_q;

	assign flush    = pix.command == CMD_FLUSH;
	assign pix_xfer = pix_valid && pix_ready;
	// flush with no row held changes nothing
	assign step     = pix_xfer && !(flush && first_row_q);
	assign emit     = step && !first_row_q;

	// while idle the read-ahead follows the clamped column
	assign col_next = !step ? col_eff : (is_last ? '0 : col_eff + AW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (step) begin
			column_q <= col_next;
			if (is_last) begin
				// a flush row ends the frame, the next one starts fresh
				first_row_q <= flush;
			end
		end
	end

	assign cur_px.red   = pix.red;
	assign cur_px.green = pix.green;
	assign cur_px.blue  = pix.blue;

	// read-ahead: always fetch the held pixel and its east neighbor for the
	// column that the next transfer will see
	fded_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (pix_xfer && !flush),
		.waddr   (col_eff),
		.wdata   (cur_px),
		.raddr_a (col_next),
		.raddr_b (col_next + AW'(1)),
		.rdata_a (rd_p),
		.rdata_b (rd_e)
	);

	// pipeline flow
	assign out_free  = !res_valid_q || res_ready;
	assign s1_fire   = valid_s1 && out_free;
	assign pix_ready = (!valid_s1 || out_free) && !cfg_we && !cfg_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// operand capture: held pixel, east neighbor, south neighbor
	always_ff @(posedge clk) begin
		if (emit) begin
			p_s1       <= rd_p;
			e_s1       <= rd_e;
			s_s1       <= cur_px;
			pass_s1    <= flush || is_last;
			row_end_s1 <= is_last;
		end
	end

	assign kern_cfg.mode      = mode_q;
	assign kern_cfg.threshold = threshold_q;

	fded_kernel u_kernel (
		.p         (p_s1),
		.e         (e_s1),
		.s         (s_s1),
		.pass_thru (pass_s1),
		.cfg       (kern_cfg),
		.px        (kern_px)
	);

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q.out_red   <= kern_px.red;
			res_q.out_green <= kern_px.green;
			res_q.out_blue  <= kern_px.blue;
			res_q.row_end   <= row_end_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// no pixel transfer while the read-ahead reloads after a cfg write
	a_cfg_blocks_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we || cfg_busy_q) |-> !pix_ready)
		else $error("pixel transfer open during configuration write");

	// the last pixel of a row wraps the column
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_last) |=> (column_q == '0))
		else $error("column did not wrap after row end");

	// a flush with no row held leaves the row state alone
	a_idle_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_xfer && flush && first_row_q) |=> ($stable(column_q) && first_row_q))
		else $error("flush with empty line store changed state");

	// an operand stage that moves always lands in the result register
	a_s1_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> res_valid_q)
		else $error("operand stage advanced without a result");

	// first row pixels never produce a result
	a_first_row_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_xfer && first_row_q && !valid_s1) |=> !valid_s1)
		else $error("result queued while no row was held");
`endif

endmodule
